FILE: hw/rtl/ltbs_pkg.sv
package ltbs_pkg;

    localparam int LUX_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_LUX_FULL_SCALE = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_BRIGHTNESS = 2'd1;
    localparam logic [IDX_W-1:0] REG_MIN_BRIGHTNESS = 2'd2;
    localparam logic [IDX_W-1:0] REG_SMOOTHING_COEF = 2'd3;

    localparam logic [15:0] LUX_FULL_SCALE_RST = 16'd1000;
    localparam logic [7:0]  MAX_BRIGHTNESS_RST = 8'd255;
    localparam logic [7:0]  MIN_BRIGHTNESS_RST = 8'd10;
    localparam logic [7:0]  SMOOTHING_COEF_RST = 8'd230;

    // 60.0 in Q8.8.
    localparam logic [15:0] SMOOTHED_LEVEL_RST = 16'd15360;

    typedef logic [15:0] q8_8_t;

endpackage

FILE: hw/rtl/lux_to_brightness_smoother.sv
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_lux_sample[15:0]
// m_        out        m_valid / m_ready    m_lamp_level[7:0]
// cfg_      in         cfg_we (no wait)     cfg_index[1:0], cfg_data[15:0]
//
// The accepting edge also loads the operands; the item then runs through bit-serial
// division, the digit-serial square root, the shift-add multiply, the shift-add blend
// and a commit. A sample of zero lux skips the division. The input is ready only while
// the sequencer is idle, from the cycle after the commit, so no new sample is taken
// before the last one is through. A result waits in the output register; the commit of
// the next one stalls until that register is free.
// Reset is synchronous and active low; it restores the register defaults and the level 60.0.
module lux_to_brightness_smoother
    import ltbs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [LUX_W-1:0]   s_lux_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [LEVEL_W-1:0] m_lamp_level,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_MIX  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] lux_full_scale_reg;
    logic [7:0]  max_brightness_reg, min_brightness_reg, smoothing_coef_reg;
    q8_8_t       level_reg, level_next;
    logic [15:0] full_reg, full_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [9:0]  srem_reg, srem_next;
    logic [7:0]  root_reg, root_next;
    logic [15:0] mcand_reg, mcand_next;
    logic [7:0]  mplier_reg, mplier_next;
    logic [15:0] prod_reg, prod_next;
    logic [23:0] acc_reg, acc_next;
    logic [23:0] old_sh_reg, old_sh_next;
    logic [23:0] tgt_sh_reg, tgt_sh_next;
    logic [8:0]  a_sh_reg, a_sh_next;
    logic [8:0]  b_sh_reg, b_sh_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_lamp_level_reg, m_lamp_level_next;

    logic [15:0] full_eff, lux_clamped, diff;
    logic [16:0] rem_shift;
    logic        div_ge;
    logic [11:0] sq_cur, sq_trial;
    logic        sq_ge;
    logic [15:0] prod_sum, floor_q, target;
    logic [23:0] mix_sum;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_lamp_level = m_lamp_level_reg;

    always_comb begin
        full_eff    = (lux_full_scale_reg == 16'd0) ? 16'd1 : lux_full_scale_reg;
        lux_clamped = (s_lux_sample > full_eff) ? full_eff : s_lux_sample;
        diff        = full_eff - lux_clamped;

        rem_shift = {rem_reg, 1'b0};
        div_ge    = (rem_shift >= {1'b0, full_reg});

        sq_cur   = {srem_reg, quo_reg[15:14]};
        sq_trial = {2'b00, root_reg, 2'b01};
        sq_ge    = (sq_cur >= sq_trial);

        prod_sum = prod_reg + (mplier_reg[0] ? mcand_reg : 16'd0);
        floor_q  = {min_brightness_reg, 8'd0};
        target   = (prod_sum < floor_q) ? floor_q : prod_sum;

        mix_sum = acc_reg + (a_sh_reg[0] ? old_sh_reg : 24'd0)
                          + (b_sh_reg[0] ? tgt_sh_reg : 24'd0);
    end

    always_comb begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        level_next        = level_reg;
        full_next         = full_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        srem_next         = srem_reg;
        root_next         = root_reg;
        mcand_next        = mcand_reg;
        mplier_next       = mplier_reg;
        prod_next         = prod_reg;
        acc_next          = acc_reg;
        old_sh_next       = old_sh_reg;
        tgt_sh_next       = tgt_sh_reg;
        a_sh_next         = a_sh_reg;
        b_sh_next         = b_sh_reg;
        m_valid_next      = m_valid_reg;
        m_lamp_level_next = m_lamp_level_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    full_next = full_eff;
                    rem_next  = diff;
                    cnt_next  = 4'd0;
                    srem_next = 10'd0;
                    root_next = 8'd0;
                    // With no light the ratio is exactly 1.0, which saturates.
                    if (diff == full_eff) begin
                        quo_next   = 16'hFFFF;
                        state_next = ST_SQRT;
                    end else begin
                        quo_next   = 16'd0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rem_next = div_ge ? 16'(rem_shift - {1'b0, full_reg}) : rem_shift[15:0];
                quo_next = {quo_reg[14:0], div_ge};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    cnt_next   = 4'd0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                srem_next = sq_ge ? 10'(sq_cur - sq_trial) : sq_cur[9:0];
                root_next = {root_reg[6:0], sq_ge};
                quo_next  = {quo_reg[13:0], 2'b00};
                cnt_next  = cnt_reg + 4'd1;
                if (cnt_reg == 4'd7) begin
                    cnt_next    = 4'd0;
                    mcand_next  = {8'd0, root_reg[6:0], sq_ge};
                    mplier_next = max_brightness_reg;
                    prod_next   = 16'd0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next   = prod_sum;
                mcand_next  = {mcand_reg[14:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[7:1]};
                cnt_next    = cnt_reg + 4'd1;
                if (cnt_reg == 4'd7) begin
                    cnt_next    = 4'd0;
                    acc_next    = 24'd0;
                    old_sh_next = {8'd0, level_reg};
                    tgt_sh_next = {8'd0, target};
                    a_sh_next   = {1'b0, smoothing_coef_reg};
                    b_sh_next   = 9'd256 - {1'b0, smoothing_coef_reg};
                    state_next  = ST_MIX;
                end
            end
            ST_MIX: begin
                acc_next    = mix_sum;
                old_sh_next = {old_sh_reg[22:0], 1'b0};
                tgt_sh_next = {tgt_sh_reg[22:0], 1'b0};
                a_sh_next   = {1'b0, a_sh_reg[8:1]};
                b_sh_next   = {1'b0, b_sh_reg[8:1]};
                cnt_next    = cnt_reg + 4'd1;
                if (cnt_reg == 4'd8) begin
                    cnt_next   = 4'd0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // The level and the result commit together once the output is free.
                if (!m_valid_reg || m_ready) begin
                    level_next        = acc_reg[23:8];
                    m_lamp_level_next = acc_reg[23:16];
                    m_valid_next      = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            cnt_reg            <= 4'd0;
            level_reg          <= SMOOTHED_LEVEL_RST;
            m_valid_reg        <= 1'b0;
            lux_full_scale_reg <= LUX_FULL_SCALE_RST;
            max_brightness_reg <= MAX_BRIGHTNESS_RST;
            min_brightness_reg <= MIN_BRIGHTNESS_RST;
            smoothing_coef_reg <= SMOOTHING_COEF_RST;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            level_reg   <= level_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_LUX_FULL_SCALE: lux_full_scale_reg <= cfg_data;
                    REG_MAX_BRIGHTNESS: max_brightness_reg <= cfg_data[7:0];
                    REG_MIN_BRIGHTNESS: min_brightness_reg <= cfg_data[7:0];
                    REG_SMOOTHING_COEF: smoothing_coef_reg <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        full_reg         <= full_next;
        rem_reg          <= rem_next;
        quo_reg          <= quo_next;
        srem_reg         <= srem_next;
        root_reg         <= root_next;
        mcand_reg        <= mcand_next;
        mplier_reg       <= mplier_next;
        prod_reg         <= prod_next;
        acc_reg          <= acc_next;
        old_sh_reg       <= old_sh_next;
        tgt_sh_reg       <= tgt_sh_next;
        a_sh_reg         <= a_sh_next;
        b_sh_reg         <= b_sh_next;
        m_lamp_level_reg <= m_lamp_level_next;
    end

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DIV || state_reg == ST_SQRT))
        else $error("accepted item did not start the divide or root");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < full_reg))
        else $error("division remainder reached the divisor");

    a_sqrt_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQRT) |-> (srem_reg <= {1'b0, root_reg, 1'b0}))
        else $error("root remainder exceeds twice the partial root");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result appeared without a commit");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_ready) |=> (state_reg == ST_DONE))
        else $error("pending result was overwritten");
`endif

endmodule
